// ===== design/mrt_pkg.sv =====
// Package for the mapped region table: sizes, codes, entry and result types,
// and the free-slot search. Used by the core, the checker and the testbench; depends on nothing.
package mrt_pkg;

   localparam int TABLE_ENTRIES = 64;
   localparam int PAGE_BYTES    = 4096;
   localparam int OWNER_COUNT   = 64;
   localparam int IDX_BITS      = $clog2(TABLE_ENTRIES);
   localparam int CNT_BITS      = $clog2(TABLE_ENTRIES + 1);
   localparam int PAGE_BITS     = $clog2(PAGE_BYTES);
   localparam int OWNER_BITS    = 6;
   localparam logic [31:0] MAP_BASE_RESET = 32'h4000_0000;

   typedef enum logic [1:0] {
      OP_MAP   = 2'd0,
      OP_FAULT = 2'd1,
      OP_UNMAP = 2'd2,
      OP_FORK  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_BAD_LENGTH = 3'd1,
      ST_NO_DESC    = 3'd2,
      ST_RIGHTS     = 3'd3,
      ST_FULL       = 3'd4,
      ST_NO_REGION  = 3'd5,
      ST_WRITE_PROH = 3'd6
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MAP,
      S_SCAN,
      S_FORK_RD,
      S_FORK_WR,
      S_DONE
   } state_type;

   localparam logic [1:0] SRC_NONE    = 2'd0;
   localparam logic [1:0] SRC_NO_FILE = 2'd1;
   localparam logic [1:0] SRC_OPEN    = 2'd2;

   typedef struct packed {
      logic [OWNER_BITS-1:0] owner;
      logic [31:0]           start;
      logic [30:0]           length;
      logic [30:0]           file_offset;
      logic [1:0]            prot;
      logic                  anonymous;
   } entry_type;

   localparam int ENTRY_BITS = $bits(entry_type);

   typedef struct packed {
      logic [2:0]          status;
      logic [31:0]         address;
      logic [30:0]         length;
      logic [IDX_BITS-1:0] slot;
      logic [1:0]          prot;
      logic                grant_write;
      logic                file_mapping;
      logic [30:0]         file_offset;
      logic [CNT_BITS-1:0] copied;
   } result_type;

   typedef struct packed {
      logic                found;
      logic [IDX_BITS-1:0] idx;
   } free_type;

   function automatic free_type find_free(input logic [TABLE_ENTRIES-1:0] valid);
      free_type f;
      f = '0;
      for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
         if (!valid[i]) begin
            f.found = 1'b1;
            f.idx   = IDX_BITS'(i);
         end
      end
      return f;
   endfunction

endpackage

// ===== design/mapped_region_table_core.sv =====
// Top level of the mapped region table: handshakes, control sequencer and valid bits.
// Depends on mrt_pkg and mrt_region_ram.
//
// Fault, unmap and fork walk the entry RAM one slot per cycle, a fault or unmap until it
// finds its region. A fork then walks the table again and takes an extra state (S_FORK_WR)
// for each region of the parent. The single read port of the entry RAM sets this pace.
// A new request is taken while the last response still waits in its output register.
module mapped_region_table_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_map_base,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_op,
   input  logic [5:0]  req_owner,
   input  logic [5:0]  req_child_owner,
   input  logic [31:0] req_address,
   input  logic signed [31:0] req_length,
   input  logic [1:0]  req_prot,
   input  logic        req_anonymous,
   input  logic [1:0]  req_file_source,
   input  logic [1:0]  req_file_access,
   input  logic [30:0] req_file_offset,
   input  logic        req_is_write,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_address_out,
   output logic [30:0] rsp_length_out,
   output logic [5:0]  rsp_slot,
   output logic [1:0]  rsp_prot_out,
   output logic        rsp_grant_write,
   output logic        rsp_file_mapping,
   output logic [30:0] rsp_file_offset_out,
   output logic [6:0]  rsp_copied_count
);

   localparam int N  = mrt_pkg::TABLE_ENTRIES;
   localparam int IB = mrt_pkg::IDX_BITS;

   mrt_pkg::state_type state_ff, state_in;
   logic [31:0] map_base_ff;
   logic [N-1:0] valid_ff, valid_in;
   logic [N-1:0] src_ff, src_in;
   logic [IB:0] rd_idx_ff, rd_idx_in;
   logic chk_valid_ff, chk_valid_in;
   logic [IB-1:0] chk_idx_ff, chk_idx_in;
   logic [mrt_pkg::CNT_BITS-1:0] cnt_ff, cnt_in;
   mrt_pkg::result_type res_ff, res_in, out_ff, out_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic [1:0]  op_ff;
   logic [5:0]  owner_ff, child_ff;
   logic [31:0] addr_ff, len_ff;
   logic [1:0]  prot_ff, fsrc_ff, facc_ff;
   logic        anon_ff, wr_ff;
   logic [30:0] foff_ff;

   logic mem_we, mem_re;
   logic [IB-1:0] mem_waddr, mem_raddr;
   mrt_pkg::entry_type mem_wdata, ent;
   mrt_pkg::free_type free;

   logic [31:0] page, start_new;
   logic covers, owner_hit, req_fire;
   logic len_bad, desc_bad, rights_bad;

   assign req_fire  = req_valid && req_ready;
   assign req_ready = (state_ff == mrt_pkg::S_IDLE);
   assign csr_ready = 1'b1;
   assign free      = mrt_pkg::find_free(valid_ff);
   assign page      = {addr_ff[31:mrt_pkg::PAGE_BITS], {mrt_pkg::PAGE_BITS{1'b0}}};
   assign start_new = map_base_ff + addr_ff;
   assign owner_hit = (ent.owner == owner_ff);
   assign covers    = ({1'b0, ent.start} <= {1'b0, page}) &&
                      ({1'b0, page} < ({1'b0, ent.start} + {2'b0, ent.length}));
   assign len_bad   = (len_ff == 32'd0) || len_ff[31] ||
                      (len_ff[mrt_pkg::PAGE_BITS-1:0] != '0);
   assign desc_bad  = !anon_ff && (fsrc_ff == mrt_pkg::SRC_NONE);
   assign rights_bad = !anon_ff && fsrc_ff[1] &&
                       ((prot_ff[0] && !facc_ff[0]) || (prot_ff[1] && !facc_ff[1]));

   mrt_region_ram #(
      .WIDTH (mrt_pkg::ENTRY_BITS),
      .DEPTH (N)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (ent)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         map_base_ff <= mrt_pkg::MAP_BASE_RESET;
      end else if (csr_valid && csr_ready) begin
         map_base_ff <= csr_map_base;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff    <= req_op;
         owner_ff <= req_owner;
         child_ff <= req_child_owner;
         addr_ff  <= req_address;
         len_ff   <= req_length;
         prot_ff  <= req_prot;
         anon_ff  <= req_anonymous;
         fsrc_ff  <= req_file_source;
         facc_ff  <= req_file_access;
         foff_ff  <= req_file_offset;
         wr_ff    <= req_is_write;
      end
      src_ff     <= src_in;
      rd_idx_ff  <= rd_idx_in;
      chk_idx_ff <= chk_idx_in;
      cnt_ff     <= cnt_in;
      res_ff     <= res_in;
      out_ff     <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mrt_pkg::S_IDLE;
         valid_ff     <= '0;
         chk_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         chk_valid_ff <= chk_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      valid_in     = valid_ff;
      src_in       = src_ff;
      rd_idx_in    = rd_idx_ff;
      chk_valid_in = 1'b0;
      chk_idx_in   = chk_idx_ff;
      cnt_in       = cnt_ff;
      res_in       = res_ff;
      out_in       = out_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      mem_we       = 1'b0;
      mem_waddr    = free.idx;
      mem_wdata    = ent;
      mem_re       = 1'b0;
      mem_raddr    = rd_idx_ff[IB-1:0];

      unique case (state_ff)
         mrt_pkg::S_IDLE: begin
            if (req_fire) begin
               res_in    = '0;
               rd_idx_in = '0;
               src_in    = '0;
               cnt_in    = '0;
               state_in  = (mrt_pkg::op_type'(req_op) == mrt_pkg::OP_MAP) ?
                           mrt_pkg::S_MAP : mrt_pkg::S_SCAN;
            end
         end
         mrt_pkg::S_MAP: begin
            state_in = mrt_pkg::S_DONE;
            if (len_bad) begin
               res_in.status = mrt_pkg::ST_BAD_LENGTH;
            end else if (desc_bad) begin
               res_in.status = mrt_pkg::ST_NO_DESC;
            end else if (rights_bad) begin
               res_in.status = mrt_pkg::ST_RIGHTS;
            end else if (!free.found) begin
               res_in.status = mrt_pkg::ST_FULL;
            end else begin
               mem_we                = 1'b1;
               mem_wdata.owner       = owner_ff;
               mem_wdata.start       = start_new;
               mem_wdata.length      = len_ff[30:0];
               mem_wdata.file_offset = foff_ff;
               mem_wdata.prot        = prot_ff;
               mem_wdata.anonymous   = anon_ff;
               valid_in[free.idx]    = 1'b1;
               res_in.status         = mrt_pkg::ST_OK;
               res_in.address        = start_new;
               res_in.slot           = free.idx;
            end
         end
         mrt_pkg::S_SCAN: begin
            if (!rd_idx_ff[IB]) begin
               mem_re       = 1'b1;
               chk_valid_in = 1'b1;
               chk_idx_in   = rd_idx_ff[IB-1:0];
               rd_idx_in    = rd_idx_ff + 1'b1;
            end
            if (chk_valid_ff && valid_ff[chk_idx_ff]) begin
               case (mrt_pkg::op_type'(op_ff))
                  mrt_pkg::OP_FAULT: begin
                     if (owner_hit && covers) begin
                        chk_valid_in   = 1'b0;
                        state_in       = mrt_pkg::S_DONE;
                        res_in.address = page;
                        res_in.slot    = chk_idx_ff;
                        res_in.prot    = ent.prot;
                        if (wr_ff && !ent.prot[1]) begin
                           res_in.status = mrt_pkg::ST_WRITE_PROH;
                        end else begin
                           res_in.status      = mrt_pkg::ST_OK;
                           res_in.grant_write = wr_ff;
                           if (!ent.anonymous) begin
                              res_in.file_mapping   = 1'b1;
                              res_in.file_offset    = ent.file_offset;
                              mem_we                = 1'b1;
                              mem_waddr             = chk_idx_ff;
                              mem_wdata.file_offset = ent.file_offset +
                                                      31'(mrt_pkg::PAGE_BYTES);
                           end
                        end
                     end
                  end
                  mrt_pkg::OP_UNMAP: begin
                     if (ent.start == addr_ff) begin
                        chk_valid_in         = 1'b0;
                        state_in             = mrt_pkg::S_DONE;
                        valid_in[chk_idx_ff] = 1'b0;
                        res_in.status        = mrt_pkg::ST_OK;
                        res_in.address       = ent.start;
                        res_in.length        = ent.length;
                        res_in.slot          = chk_idx_ff;
                     end
                  end
                  default: begin
                     if (owner_hit) begin
                        src_in[chk_idx_ff] = 1'b1;
                     end
                  end
               endcase
            end
            if (!chk_valid_ff && rd_idx_ff[IB]) begin
               if (mrt_pkg::op_type'(op_ff) == mrt_pkg::OP_FORK) begin
                  rd_idx_in     = '0;
                  res_in.status = mrt_pkg::ST_OK;
                  state_in      = mrt_pkg::S_FORK_RD;
               end else begin
                  res_in.status = mrt_pkg::ST_NO_REGION;
                  if (mrt_pkg::op_type'(op_ff) == mrt_pkg::OP_FAULT) begin
                     res_in.address = page;
                  end
                  state_in = mrt_pkg::S_DONE;
               end
            end
         end
         mrt_pkg::S_FORK_RD: begin
            if (rd_idx_ff[IB]) begin
               res_in.copied = cnt_ff;
               state_in      = mrt_pkg::S_DONE;
            end else if (src_ff[rd_idx_ff[IB-1:0]]) begin
               mem_re   = 1'b1;
               state_in = mrt_pkg::S_FORK_WR;
            end else begin
               rd_idx_in = rd_idx_ff + 1'b1;
            end
         end
         mrt_pkg::S_FORK_WR: begin
            if (free.found) begin
               mem_we             = 1'b1;
               mem_wdata.owner    = child_ff;
               valid_in[free.idx] = 1'b1;
               cnt_in             = cnt_ff + 1'b1;
            end else begin
               res_in.status = mrt_pkg::ST_FULL;
            end
            rd_idx_in = rd_idx_ff + 1'b1;
            state_in  = mrt_pkg::S_FORK_RD;
         end
         mrt_pkg::S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               out_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = mrt_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = mrt_pkg::S_IDLE;
         end
      endcase
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = out_ff.status;
   assign rsp_address_out     = out_ff.address;
   assign rsp_length_out      = out_ff.length;
   assign rsp_slot            = out_ff.slot;
   assign rsp_prot_out        = out_ff.prot;
   assign rsp_grant_write     = out_ff.grant_write;
   assign rsp_file_mapping    = out_ff.file_mapping;
   assign rsp_file_offset_out = out_ff.file_offset;
   assign rsp_copied_count    = out_ff.copied;

   a_map_sets_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mrt_pkg::S_MAP && mem_we) |=> valid_ff[$past(free.idx)])
      else $error("Mapped slot is not marked valid.");

   a_unmap_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mrt_pkg::S_SCAN && mem_re == 1'b0 && chk_valid_ff &&
       !valid_in[chk_idx_ff] && valid_ff[chk_idx_ff]) |=> !valid_ff[$past(chk_idx_ff)])
      else $error("Unmapped slot is still valid.");

   a_check_follows_read: assert property (@(posedge clock) disable iff (reset)
      chk_valid_ff |-> (rd_idx_ff == {1'b0, chk_idx_ff} + 1'b1))
      else $error("Scan check index is out of step with the read index.");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mrt_pkg::S_FORK_WR) |-> (cnt_ff < mrt_pkg::CNT_BITS'(N)))
      else $error("Fork copy count overran the table.");

endmodule

// ===== design/mrt_region_ram.sv =====
// Simple dual-port synchronous RAM holding the region entries.
// One write and one registered read per cycle; no dependencies.
module mrt_region_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== dv/mrt_checker.sv =====
// Checker for the mapped region table: watches the request, response and register
// channels, predicts each response from its own copy of the table and compares it.
// Depends on mrt_pkg for the sizes, codes, entry and response types.
module mrt_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [31:0] csr_map_base,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_op,
   input  logic [5:0]  req_owner,
   input  logic [5:0]  req_child_owner,
   input  logic [31:0] req_address,
   input  logic [31:0] req_length,
   input  logic [1:0]  req_prot,
   input  logic        req_anonymous,
   input  logic [1:0]  req_file_source,
   input  logic [1:0]  req_file_access,
   input  logic [30:0] req_file_offset,
   input  logic        req_is_write,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [2:0]  rsp_status,
   input  logic [31:0] rsp_address_out,
   input  logic [30:0] rsp_length_out,
   input  logic [5:0]  rsp_slot,
   input  logic [1:0]  rsp_prot_out,
   input  logic        rsp_grant_write,
   input  logic        rsp_file_mapping,
   input  logic [30:0] rsp_file_offset_out,
   input  logic [6:0]  rsp_copied_count,
   output int          failures,
   output int          pending,
   output int          responses
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [31:0]          base_shadow;
   logic                 slot_used [mrt_pkg::TABLE_ENTRIES];
   mrt_pkg::entry_type   slot_entry [mrt_pkg::TABLE_ENTRIES];
   mrt_pkg::result_type  expected_rsp [$];

   function automatic int lowest_free();
      for (int i = 0; i < mrt_pkg::TABLE_ENTRIES; i++)
         if (!slot_used[i]) return i;
      return -1;
   endfunction

   task automatic table_operation(output mrt_pkg::result_type r);
      logic [31:0] page;
      logic [32:0] top;
      logic        parent_set [mrt_pkg::TABLE_ENTRIES];
      int          s;
      int          hit;
      r = '0;
      case (mrt_pkg::op_type'(req_op))
         mrt_pkg::OP_MAP: begin
            if ($signed(req_length) <= 0 || req_length[mrt_pkg::PAGE_BITS-1:0] != '0) begin
               r.status = mrt_pkg::ST_BAD_LENGTH;
            end else if (!req_anonymous && req_file_source == mrt_pkg::SRC_NONE) begin
               r.status = mrt_pkg::ST_NO_DESC;
            end else if (!req_anonymous && req_file_source >= mrt_pkg::SRC_OPEN &&
                         ((req_prot[0] && !req_file_access[0]) ||
                          (req_prot[1] && !req_file_access[1]))) begin
               r.status = mrt_pkg::ST_RIGHTS;
            end else begin
               s = lowest_free();
               if (s < 0) begin
                  r.status = mrt_pkg::ST_FULL;
               end else begin
                  slot_used[s] = 1'b1;
                  slot_entry[s].owner       = req_owner;
                  slot_entry[s].start       = base_shadow + req_address;
                  slot_entry[s].length      = req_length[30:0];
                  slot_entry[s].file_offset = req_file_offset;
                  slot_entry[s].prot        = req_prot;
                  slot_entry[s].anonymous   = req_anonymous;
                  r.status  = mrt_pkg::ST_OK;
                  r.address = slot_entry[s].start;
                  r.slot    = s[mrt_pkg::IDX_BITS-1:0];
               end
            end
         end
         mrt_pkg::OP_FAULT: begin
            page = req_address & ~32'(mrt_pkg::PAGE_BYTES - 1);
            r.address = page;
            hit = -1;
            for (int i = 0; i < mrt_pkg::TABLE_ENTRIES && hit < 0; i++) begin
               top = {1'b0, slot_entry[i].start} + {2'b0, slot_entry[i].length};
               if (slot_used[i] && slot_entry[i].owner == req_owner &&
                   slot_entry[i].start <= page && {1'b0, page} < top)
                  hit = i;
            end
            if (hit < 0) begin
               r.status = mrt_pkg::ST_NO_REGION;
            end else begin
               r.slot = hit[mrt_pkg::IDX_BITS-1:0];
               r.prot = slot_entry[hit].prot;
               if (req_is_write && !slot_entry[hit].prot[1]) begin
                  r.status = mrt_pkg::ST_WRITE_PROH;
               end else begin
                  r.status = mrt_pkg::ST_OK;
                  r.grant_write = req_is_write;
                  if (!slot_entry[hit].anonymous) begin
                     r.file_mapping = 1'b1;
                     r.file_offset  = slot_entry[hit].file_offset;
                     slot_entry[hit].file_offset = slot_entry[hit].file_offset +
                                                   31'(mrt_pkg::PAGE_BYTES);
                  end
               end
            end
         end
         mrt_pkg::OP_UNMAP: begin
            r.status = mrt_pkg::ST_NO_REGION;
            for (int i = 0; i < mrt_pkg::TABLE_ENTRIES; i++) begin
               if (r.status == mrt_pkg::ST_NO_REGION && slot_used[i] &&
                   slot_entry[i].start == req_address) begin
                  r.status  = mrt_pkg::ST_OK;
                  r.address = slot_entry[i].start;
                  r.length  = slot_entry[i].length;
                  r.slot    = i[mrt_pkg::IDX_BITS-1:0];
                  slot_used[i] = 1'b0;
               end
            end
         end
         default: begin
            r.status = mrt_pkg::ST_OK;
            for (int i = 0; i < mrt_pkg::TABLE_ENTRIES; i++)
               parent_set[i] = slot_used[i] && slot_entry[i].owner == req_owner;
            for (int i = 0; i < mrt_pkg::TABLE_ENTRIES; i++) begin
               if (parent_set[i]) begin
                  s = lowest_free();
                  if (s < 0) begin
                     r.status = mrt_pkg::ST_FULL;
                  end else begin
                     slot_used[s]  = 1'b1;
                     slot_entry[s] = slot_entry[i];
                     slot_entry[s].owner = req_child_owner;
                     r.copied = r.copied + 1'b1;
                  end
               end
            end
         end
      endcase
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      mrt_pkg::result_type r;
      if (reset) begin
         base_shadow = mrt_pkg::MAP_BASE_RESET;
         for (int i = 0; i < mrt_pkg::TABLE_ENTRIES; i++) begin
            slot_used[i]  = 1'b0;
            slot_entry[i] = '0;
         end
         expected_rsp.delete();
         failures  = 0;
         responses = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            responses++;
            if (expected_rsp.size() == 0) begin
               $error("response beat with no request outstanding");
               failures++;
            end else begin
               r = expected_rsp.pop_front();
               check_field("status", 32'(r.status), 32'(rsp_status));
               check_field("address_out", r.address, rsp_address_out);
               check_field("length_out", 32'(r.length), 32'(rsp_length_out));
               check_field("slot", 32'(r.slot), 32'(rsp_slot));
               check_field("prot_out", 32'(r.prot), 32'(rsp_prot_out));
               check_field("grant_write", 32'(r.grant_write), 32'(rsp_grant_write));
               check_field("file_mapping", 32'(r.file_mapping), 32'(rsp_file_mapping));
               check_field("file_offset_out", 32'(r.file_offset),
                           32'(rsp_file_offset_out));
               check_field("copied_count", 32'(r.copied), 32'(rsp_copied_count));
            end
         end
         if (csr_valid && csr_ready)
            base_shadow = csr_map_base;
         if (req_valid && req_ready) begin
            table_operation(r);
            expected_rsp.push_back(r);
         end
      end
      pending = expected_rsp.size();
   end

endmodule

// ===== dv/tb.sv =====
// Top of the mapped region table testbench: clock, reset, request and register
// stimulus, response back-pressure, watchdog and verdict.
// Depends on mrt_pkg, mapped_region_table_core and mrt_checker.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int ITEMS_PER_PHASE = 250;

   typedef struct {
      logic [1:0]  op;
      logic [5:0]  owner;
      logic [5:0]  child_owner;
      logic [31:0] address;
      logic [31:0] length;
      logic [1:0]  prot;
      logic        anonymous;
      logic [1:0]  file_source;
      logic [1:0]  file_access;
      logic [30:0] file_offset;
      logic        is_write;
   } request_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [31:0] csr_map_base = '0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_op = '0;
   logic [5:0]  req_owner = '0;
   logic [5:0]  req_child_owner = '0;
   logic [31:0] req_address = '0;
   logic [31:0] req_length = '0;
   logic [1:0]  req_prot = '0;
   logic        req_anonymous = 1'b0;
   logic [1:0]  req_file_source = '0;
   logic [1:0]  req_file_access = '0;
   logic [30:0] req_file_offset = '0;
   logic        req_is_write = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_status;
   logic [31:0] rsp_address_out;
   logic [30:0] rsp_length_out;
   logic [5:0]  rsp_slot;
   logic [1:0]  rsp_prot_out;
   logic        rsp_grant_write;
   logic        rsp_file_mapping;
   logic [30:0] rsp_file_offset_out;
   logic [6:0]  rsp_copied_count;

   int          failures;
   int          pending;
   int          responses;
   int          sent = 0;
   int          idle_pct = 0;
   int          stall_pct = 0;
   bit          hold_off = 1'b0;
   int          quiet_cycles = 0;
   logic [31:0] current_base = mrt_pkg::MAP_BASE_RESET;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   mapped_region_table_core dut (.*);

   mrt_checker u_checker (.*);

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      forever begin
         @(negedge clock);
         if (hold_off) begin
            hold_off  = 1'b0;
            rsp_ready = 1'b0;
            repeat (400) @(negedge clock);
         end
         rsp_ready = !reset && ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic send_request(input request_type r);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid       = 1'b1;
      req_op          = r.op;
      req_owner       = r.owner;
      req_child_owner = r.child_owner;
      req_address     = r.address;
      req_length      = r.length;
      req_prot        = r.prot;
      req_anonymous   = r.anonymous;
      req_file_source = r.file_source;
      req_file_access = r.file_access;
      req_file_offset = r.file_offset;
      req_is_write    = r.is_write;
      do @(posedge clock); while (!req_ready);
      sent++;
   endtask

   task automatic write_base(input logic [31:0] value);
      @(negedge clock);
      req_valid = 1'b0;
      while (pending != 0) @(negedge clock);
      csr_valid    = 1'b1;
      csr_map_base = value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid    = 1'b0;
      current_base = value;
   endtask

   function automatic request_type make_request(input mrt_pkg::op_type op,
                                                input logic [5:0] owner,
                                                input logic [31:0] address,
                                                input logic [31:0] length);
      request_type r;
      r.op          = op;
      r.owner       = owner;
      r.child_owner = owner + 6'd1;
      r.address     = address;
      r.length      = length;
      r.prot        = 2'b11;
      r.anonymous   = 1'b1;
      r.file_source = mrt_pkg::SRC_OPEN;
      r.file_access = 2'b11;
      r.file_offset = '0;
      r.is_write    = 1'b0;
      return r;
   endfunction

   function automatic request_type random_request();
      request_type r;
      int          pick;
      logic [31:0] offset;
      pick   = $urandom_range(99);
      offset = 32'($urandom_range(15)) * mrt_pkg::PAGE_BYTES;
      r.owner       = ($urandom_range(9) == 0) ? 6'($urandom) : 6'($urandom_range(3));
      r.child_owner = ($urandom_range(3) == 0) ? 6'($urandom) : 6'($urandom_range(3));
      r.prot        = 2'($urandom);
      r.anonymous   = 1'($urandom);
      r.file_source = ($urandom_range(19) == 0) ? 2'd3 : 2'($urandom_range(2));
      r.file_access = 2'($urandom);
      r.file_offset = 31'($urandom);
      r.is_write    = 1'($urandom);
      r.length      = 32'($urandom_range(1, 4)) * mrt_pkg::PAGE_BYTES;
      if ($urandom_range(9) == 0)
         r.length = ($urandom_range(1) == 0) ? 32'($urandom) : 32'($urandom_range(0, 8191));
      if (pick < 35) begin
         r.op      = mrt_pkg::OP_MAP;
         r.address = ($urandom_range(19) == 0) ? 32'($urandom) : offset;
      end else if (pick < 67) begin
         r.op      = mrt_pkg::OP_FAULT;
         r.address = current_base + offset + 32'($urandom_range(4 * mrt_pkg::PAGE_BYTES));
         if ($urandom_range(19) == 0) r.address = 32'($urandom);
      end else if (pick < 95) begin
         r.op      = mrt_pkg::OP_UNMAP;
         r.address = current_base + offset;
         if ($urandom_range(19) == 0) r.address = 32'($urandom);
      end else begin
         r.op      = mrt_pkg::OP_FORK;
         r.address = 32'($urandom);
      end
      return r;
   endfunction

   task automatic directed_items();
      request_type r;
      write_base(mrt_pkg::MAP_BASE_RESET);
      send_request(make_request(mrt_pkg::OP_MAP, 6'd0, 32'h0, 32'h0000_2000));
      send_request(make_request(mrt_pkg::OP_MAP, 6'd0, 32'h0, 32'h0));
      send_request(make_request(mrt_pkg::OP_MAP, 6'd0, 32'h0, 32'h8000_0000));
      send_request(make_request(mrt_pkg::OP_MAP, 6'd0, 32'h0, 32'hFFFF_F000));
      send_request(make_request(mrt_pkg::OP_MAP, 6'd0, 32'h0, 32'h0000_1001));
      r = make_request(mrt_pkg::OP_MAP, 6'd63, 32'h10_0000, 32'h7FFF_F000);
      r.anonymous = 1'b0; r.file_source = mrt_pkg::SRC_NONE;
      send_request(r);
      r.file_source = mrt_pkg::SRC_OPEN; r.file_access = 2'b10; r.prot = 2'b01;
      send_request(r);
      r.file_access = 2'b01; r.prot = 2'b10;
      send_request(r);
      r.file_source = mrt_pkg::SRC_NO_FILE; r.file_access = 2'b00; r.prot = 2'b01;
      r.file_offset = 31'h7FFF_F800;
      send_request(r);
      r = make_request(mrt_pkg::OP_FAULT, 6'd63, 32'h4010_0FFF, 32'h0);
      send_request(r);
      send_request(r);
      r.is_write = 1'b1;
      send_request(r);
      r = make_request(mrt_pkg::OP_FAULT, 6'd0, 32'h4000_1ABC, 32'h0);
      r.is_write = 1'b1;
      send_request(r);
      send_request(make_request(mrt_pkg::OP_FAULT, 6'd0, 32'h4000_2000, 32'h0));
      send_request(make_request(mrt_pkg::OP_FAULT, 6'd5, 32'h4000_0000, 32'h0));
      r = make_request(mrt_pkg::OP_FORK, 6'd0, 32'h0, 32'h0);
      r.child_owner = 6'd0;
      send_request(r);
      r.owner = 6'd63; r.child_owner = 6'd7;
      send_request(r);
      send_request(make_request(mrt_pkg::OP_FAULT, 6'd7, 32'h7FFF_FFFF, 32'h0));
      send_request(make_request(mrt_pkg::OP_UNMAP, 6'd9, 32'h4000_0000, 32'h0));
      send_request(make_request(mrt_pkg::OP_UNMAP, 6'd0, 32'h4000_0000, 32'h0));
      send_request(make_request(mrt_pkg::OP_UNMAP, 6'd0, 32'h1234_5000, 32'h0));
   endtask

   initial begin
      logic [31:0] bases [5];
      bases = '{32'h0, 32'hFFFF_F000, 32'hFFFF_FFFF, 32'h0, mrt_pkg::MAP_BASE_RESET};
      bases[3] = $urandom;
      repeat (11) @(negedge clock);
      reset = 1'b0;
      directed_items();
      for (int phase = 0; phase < 5; phase++) begin
         write_base(bases[phase]);
         case (phase % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 67; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 67; end
            default: begin idle_pct = 14; stall_pct = 14; end
         endcase
         if (phase == 0) hold_off = 1'b1;
         for (int n = 0; n < ITEMS_PER_PHASE; n++)
            send_request(random_request());
      end
      @(negedge clock);
      req_valid = 1'b0;
      stall_pct = 0;
      while (pending != 0) @(negedge clock);
      repeat (250) @(negedge clock);
      $display("Summary: %0d requests and %0d responses over five base settings,", sent,
               responses);
      $display("four idle patterns and one long response hold-off.");
      if (failures == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ===== mapped_region_table_core.f =====
design/mrt_pkg.sv
design/mrt_region_ram.sv
design/mapped_region_table_core.sv
dv/mrt_checker.sv
dv/tb.sv
